// ===== rtl/core/sse_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sse_pkg
// Shared constants for the sprite scanline evaluation block: item kinds,
// fill byte, scan steps and sprite heights.
// ============================================================================
package sse_pkg;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVAL  = 1'b1;

    localparam logic [7:0] EMPTY_BYTE = 8'hFF;

    localparam int SPRITE_STEP = 4;
    localparam int OVF_STEP    = 4 + 1;

    localparam logic [4:0] HEIGHT_SHORT = 5'd8;
    localparam logic [4:0] HEIGHT_TALL  = 5'd16;

endpackage

// ===== rtl/core/sse_range_check.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sse_range_check
// Tells whether a Y byte puts its sprite on the line after scan_line.
// ============================================================================
module sse_range_check (
    input  logic [7:0] y_byte,
    input  logic [8:0] scan_line,
    input  logic       tall_sprites,
    output logic       hit
);

    logic [10:0] line_next;
    logic [10:0] y_ext;
    logic [10:0] diff;
    logic [10:0] height;

    assign line_next = 11'(scan_line) + 11'd1;
    assign y_ext     = 11'(y_byte);
    assign diff      = line_next - y_ext;
    assign height    = tall_sprites ? 11'(sse_pkg::HEIGHT_TALL)
                                    : 11'(sse_pkg::HEIGHT_SHORT);
    assign hit       = (line_next >= y_ext) && (diff < height);

endmodule

// ===== rtl/core/sprite_scanline_evaluation.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sprite_scanline_evaluation
// Sprite table with per-scanline evaluation into secondary slots.
// ============================================================================
// A write beat stores one byte into the 256-byte sprite table. An
// evaluate beat scans the table through its single read port, one byte per
// access: a read state and a check state for each sprite Y byte and for each
// of the three further bytes of a sprite taken into a slot, a read and a check
// per probe of the overflow search, then a slot read and an output load per
// slot result (the load waits on output stalls). Slot contents sit in a
// SLOTS x 32-bit buffer; slots past the last find read as 0xFF bytes, so no
// clearing pass is needed. The input side takes a new beat while the last
// result of the previous evaluation still waits in the output register.
// ============================================================================
module sprite_scanline_evaluation #(
    parameter int SLOTS = 8
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_kind,
    input  logic [7:0] s_table_addr,
    input  logic [7:0] s_table_data,
    input  logic [8:0] s_scan_line,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_slot,
    output logic [7:0] m_y_byte,
    output logic [7:0] m_tile_byte,
    output logic [7:0] m_attr_byte,
    output logic [7:0] m_x_byte,
    output logic       m_overflow,
    output logic       m_last
);

    localparam int KW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW = $clog2(SLOTS + 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN_RD = 3'd1;
    localparam logic [2:0] ST_SCAN_CK = 3'd2;
    localparam logic [2:0] ST_OVF_RD  = 3'd3;
    localparam logic [2:0] ST_OVF_CK  = 3'd4;
    localparam logic [2:0] ST_EMIT_RD = 3'd5;
    localparam logic [2:0] ST_EMIT_LD = 3'd6;

    logic [7:0]  tbl_mem [256];
    logic [31:0] slot_mem [SLOTS];

    logic [2:0]    state_reg, state_next;
    logic          tall_reg, tall_next;
    logic [8:0]    line_reg, line_next;
    logic [8:0]    addr_reg, addr_next;
    logic [1:0]    bsel_reg, bsel_next;
    logic [FW-1:0] found_reg, found_next;
    logic [KW-1:0] k_reg, k_next;
    logic          ovf_reg, ovf_next;
    logic [23:0]   word_reg, word_next;

    logic          m_valid_reg, m_valid_next;
    logic [2:0]    m_slot_reg, m_slot_next;
    logic [31:0]   m_bytes_reg, m_bytes_next;
    logic          m_ovf_reg, m_ovf_next;
    logic          m_last_reg, m_last_next;

    logic [7:0]    tbl_rdata_reg;
    logic [31:0]   slot_rdata_reg;
    logic [7:0]    tbl_raddr;
    logic          tbl_we;
    logic          slot_we;
    logic          hit;

    logic [8:0]    addr_step4;
    logic [8:0]    addr_step5;
    logic [FW-1:0] found_inc;
    logic [KW+2:0] k_ext;
    logic          s_fire;

    sse_range_check u_range (
        .y_byte       (tbl_rdata_reg),
        .scan_line    (line_reg),
        .tall_sprites (tall_reg),
        .hit          (hit)
    );

    assign cfg_ready  = 1'b1;
    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign addr_step4 = addr_reg + 9'(sse_pkg::SPRITE_STEP);
    assign addr_step5 = addr_reg + 9'(sse_pkg::OVF_STEP);
    assign found_inc  = found_reg + FW'(1);
    assign k_ext      = {3'b000, k_reg};

    assign tbl_we  = s_fire && (s_kind == sse_pkg::KIND_WRITE);
    assign slot_we = (state_reg == ST_SCAN_CK) && (bsel_reg == 2'd3);

    always_comb begin
        case (state_reg)
            ST_SCAN_RD: tbl_raddr = {addr_reg[7:2], bsel_reg};
            default:    tbl_raddr = addr_reg[7:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[s_table_addr] <= s_table_data;
        end
        tbl_rdata_reg <= tbl_mem[tbl_raddr];
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[found_reg[KW-1:0]] <= {tbl_rdata_reg, word_reg};
        end
        slot_rdata_reg <= slot_mem[k_reg];
    end

    always_comb begin
        state_next   = state_reg;
        tall_next    = tall_reg;
        line_next    = line_reg;
        addr_next    = addr_reg;
        bsel_next    = bsel_reg;
        found_next   = found_reg;
        k_next       = k_reg;
        ovf_next     = ovf_reg;
        word_next    = word_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_slot_next  = m_slot_reg;
        m_bytes_next = m_bytes_reg;
        m_ovf_next   = m_ovf_reg;
        m_last_next  = m_last_reg;

        if (cfg_valid && cfg_ready) begin
            tall_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_kind == sse_pkg::KIND_EVAL)) begin
                    line_next  = s_scan_line;
                    addr_next  = '0;
                    bsel_next  = '0;
                    found_next = '0;
                    k_next     = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CK;
            end
            ST_SCAN_CK: begin
                if (bsel_reg == 2'd0) begin
                    if (hit) begin
                        word_next[7:0] = tbl_rdata_reg;
                        bsel_next      = 2'd1;
                        state_next     = ST_SCAN_RD;
                    end else begin
                        addr_next  = addr_step4;
                        state_next = addr_step4[8] ? ST_EMIT_RD : ST_SCAN_RD;
                    end
                end else if (bsel_reg == 2'd3) begin
                    found_next = found_inc;
                    bsel_next  = 2'd0;
                    addr_next  = addr_step4;
                    if (addr_step4[8]) begin
                        state_next = ST_EMIT_RD;
                    end else if (found_inc == FW'(SLOTS)) begin
                        state_next = ST_OVF_RD;
                    end else begin
                        state_next = ST_SCAN_RD;
                    end
                end else begin
                    if (bsel_reg == 2'd1) begin
                        word_next[15:8] = tbl_rdata_reg;
                    end else begin
                        word_next[23:16] = tbl_rdata_reg;
                    end
                    bsel_next  = bsel_reg + 2'd1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_OVF_RD: begin
                state_next = ST_OVF_CK;
            end
            ST_OVF_CK: begin
                if (hit) begin
                    ovf_next   = 1'b1;
                    state_next = ST_EMIT_RD;
                end else begin
                    addr_next  = addr_step5;
                    state_next = addr_step5[8] ? ST_EMIT_RD : ST_OVF_RD;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_slot_next  = k_ext[2:0];
                    m_bytes_next = (FW'(k_reg) < found_reg) ? slot_rdata_reg
                                 : {4{sse_pkg::EMPTY_BYTE}};
                    m_ovf_next   = ovf_reg;
                    m_last_next  = (k_reg == KW'(SLOTS - 1));
                    if (k_reg == KW'(SLOTS - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + KW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tall_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            found_reg   <= '0;
            ovf_reg     <= 1'b0;
            bsel_reg    <= '0;
            k_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            tall_reg    <= tall_next;
            m_valid_reg <= m_valid_next;
            found_reg   <= found_next;
            ovf_reg     <= ovf_next;
            bsel_reg    <= bsel_next;
            k_reg       <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        line_reg    <= line_next;
        addr_reg    <= addr_next;
        word_reg    <= word_next;
        m_slot_reg  <= m_slot_next;
        m_bytes_reg <= m_bytes_next;
        m_ovf_reg   <= m_ovf_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_slot      = m_slot_reg;
    assign m_y_byte    = m_bytes_reg[7:0];
    assign m_tile_byte = m_bytes_reg[15:8];
    assign m_attr_byte = m_bytes_reg[23:16];
    assign m_x_byte    = m_bytes_reg[31:24];
    assign m_overflow  = m_ovf_reg;
    assign m_last      = m_last_reg;

    a_found_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg <= FW'(SLOTS))
        else $error("slot count past SLOTS");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (found_reg == FW'(SLOTS)))
        else $error("overflow set with free slots");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
        (m_valid && $stable({m_slot_reg, m_bytes_reg, m_ovf_reg, m_last_reg})))
        else $error("result beat changed while stalled");

    a_busy_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN_CK || state_reg == ST_OVF_CK) |-> !s_ready)
        else $error("input taken during scan");

endmodule
